// ===== design/encoder_frame_tracker_defines.svh =====
// Assertion shorthands shared by the tracker modules.
// Each expects clk and rst_n in scope.
`ifndef ENCODER_FRAME_TRACKER_DEFINES_SVH
`define ENCODER_FRAME_TRACKER_DEFINES_SVH

// same-cycle implication
`define EFT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EFT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/eft_pkg.sv =====
package eft_pkg;

    // frame and timestamp
    localparam int FRAME_BITS   = 16;
    localparam int ANGLE_BITS   = 14;
    localparam int ERR_BIT      = 14;
    localparam int TIME_BITS    = 32;

    // sizing knobs
    localparam int TURN_BITS    = 24;
    localparam int TALLY_BITS   = 16;

    // result fields
    localparam int POS_BITS     = 40;
    localparam int SPEED_BITS   = 32;
    localparam int TOTAL_BITS   = 16;

    // configuration
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;
    localparam int OFFSET_BITS    = 24;
    localparam int LIMIT_BITS     = 24;
    localparam int GAIN_BITS      = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DIRECTION_CCW = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OFFSET_COUNTS = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_JUMP_LIMIT    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CALIBRATED    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN_P        = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN_I        = 3'd5;

    localparam logic [LIMIT_BITS-1:0] JUMP_LIMIT_RST = 24'd2048;
    localparam logic [GAIN_BITS-1:0]  GAIN_P_RST     = 16'd100;
    localparam logic [GAIN_BITS-1:0]  GAIN_I_RST     = 16'd300;

    // observer arithmetic
    localparam int TS_RECIP     = 4295;    // 2^32 / 1e6, seconds in Q.32 per us
    localparam int MIN_DT_US    = 100;
    localparam int TS_BITS      = 45;      // dt * TS_RECIP
    localparam int GITS_BITS    = 61;      // gain_i * ts
    localparam int E_BITS       = 57;      // tracking error, Q.16
    localparam int OBS_BITS     = 56;
    localparam int INTEG_BITS   = 48;
    localparam int RES_BITS     = 59;      // clamped product, signed
    localparam int SUM_BITS     = 60;

    // intermediate position width before clamping to POS_BITS
    localparam int POS_WIDE =
        ((TURN_BITS + ANGLE_BITS > POS_BITS) ? TURN_BITS + ANGLE_BITS : POS_BITS) + 2;

    // shared multiplier
    localparam int MUL_LIMB   = 32;
    localparam int MUL_WIDTH  = 2 * MUL_LIMB;
    localparam int PROD_WIDTH = 2 * MUL_WIDTH;
    localparam int MUL_STEPS  = 4;

    typedef struct packed {
        logic                 start;
        logic [MUL_WIDTH-1:0] a;
        logic [MUL_WIDTH-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                  done;
        logic [PROD_WIDTH-1:0] product;
    } mul_rsp_t;

endpackage

// ===== design/eft_if.sv =====
interface eft_frame_if
    import eft_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [FRAME_BITS-1:0] raw_frame;
    logic [TIME_BITS-1:0]  time_us;

    modport source (output valid, raw_frame, time_us, input ready);
    modport sink   (input valid, raw_frame, time_us, output ready);
endinterface

interface eft_result_if
    import eft_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [POS_BITS-1:0]   position;
    logic signed [SPEED_BITS-1:0] speed;
    logic                         sample_accepted;
    logic                         parity_fault;
    logic                         sensor_error_bit;
    logic                         jump_fault;
    logic                         speed_updated;
    logic [TOTAL_BITS-1:0]        parity_fault_total;
    logic [TOTAL_BITS-1:0]        error_bit_total;
    logic [TOTAL_BITS-1:0]        jump_fault_total;

    modport source (output valid, position, speed, sample_accepted, parity_fault,
                    sensor_error_bit, jump_fault, speed_updated, parity_fault_total,
                    error_bit_total, jump_fault_total, input ready);
    modport sink   (input valid, position, speed, sample_accepted, parity_fault,
                    sensor_error_bit, jump_fault, speed_updated, parity_fault_total,
                    error_bit_total, jump_fault_total, output ready);
endinterface

interface eft_cfg_if
    import eft_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/encoder_frame_tracker.sv =====
// Channel   Role    Transaction payload
// cfg       sink    index, data (register write)
// frame     sink    raw_frame, time_us
// result    source  position, speed, status flags, fault totals
//
// One frame at a time; frame.ready is high only while the sequencer is idle.
// A rejected frame goes from the check straight to the result stage; an accepted frame
// passes the position and jump steps first. An observer update adds five runs of the
// shared 32x32 limb multiplier plus integrator and angle update steps.
// The result register lets the next frame in while a result waits on a stall.
// rst_n is asynchronous; all tracking state and registers return to defaults.
`include "encoder_frame_tracker_defines.svh"

module encoder_frame_tracker
    import eft_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    eft_cfg_if.sink      cfg,
    eft_frame_if.sink    frame,
    eft_result_if.source result
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_POS, S_JUMP, S_GO, S_WAIT, S_POST,
        S_INT, S_OMEGA, S_ANGLE, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_TS, OP_GITS, OP_INC, OP_P, OP_DTH
    } op_t;

    localparam logic signed [TURN_BITS-1:0] TURN_HI = {1'b0, {(TURN_BITS-1){1'b1}}};
    localparam logic signed [TURN_BITS-1:0] TURN_LO = ~TURN_HI;
    localparam logic signed [POS_WIDE-1:0] POS_HI =
        {{(POS_WIDE-POS_BITS+1){1'b0}}, {(POS_BITS-1){1'b1}}};
    localparam logic signed [POS_WIDE-1:0] POS_LO = ~POS_HI;
    localparam logic signed [SUM_BITS-1:0] INTEG_HI =
        {{(SUM_BITS-INTEG_BITS+1){1'b0}}, {(INTEG_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] INTEG_LO = ~INTEG_HI;
    localparam logic signed [SUM_BITS-1:0] OBS_HI =
        {{(SUM_BITS-OBS_BITS+1){1'b0}}, {(OBS_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] OBS_LO = ~OBS_HI;
    localparam logic signed [ANGLE_BITS:0] HALF_TURN =
        {2'b01, {(ANGLE_BITS-1){1'b0}}};
    localparam logic [TALLY_BITS-1:0] TALLY_MAX = '1;

    // configuration
    logic                          dir_ccw_reg;
    logic signed [OFFSET_BITS-1:0] offset_reg;
    logic [LIMIT_BITS-1:0]         jump_limit_reg;
    logic                          calibrated_reg;
    logic [GAIN_BITS-1:0]          gain_p_reg;
    logic [GAIN_BITS-1:0]          gain_i_reg;

    // tracking state
    state_t                        state_reg;
    op_t                           op_reg;
    logic [FRAME_BITS-1:0]         raw_reg;
    logic [TIME_BITS-1:0]          time_reg;
    logic [ANGLE_BITS-1:0]         last_angle_reg;
    logic signed [TURN_BITS-1:0]   turn_reg;
    logic signed [POS_BITS-1:0]    pos_reg;
    logic signed [POS_BITS-1:0]    last_pos_reg;
    logic [TIME_BITS-1:0]          last_time_reg;
    logic signed [OBS_BITS-1:0]    obs_reg;
    logic signed [INTEG_BITS-1:0]  integ_reg;
    logic signed [SPEED_BITS-1:0]  speed_reg;
    logic [TALLY_BITS-1:0]         ptally_reg;
    logic [TALLY_BITS-1:0]         etally_reg;
    logic [TALLY_BITS-1:0]         jtally_reg;
    logic                          pfault_reg;
    logic                          efault_reg;
    logic                          jfault_reg;
    logic                          supd_reg;
    logic [TIME_BITS-1:0]          dt_reg;
    logic signed [E_BITS-1:0]      e_reg;
    logic [TS_BITS-1:0]            ts_reg;
    logic [GITS_BITS-1:0]          gits_reg;
    logic signed [RES_BITS-1:0]    res_reg;
    logic signed [INTEG_BITS-1:0]  omega_reg;

    // result register
    logic                          out_valid_reg;
    logic signed [POS_BITS-1:0]    out_pos_reg;
    logic signed [SPEED_BITS-1:0]  out_speed_reg;
    logic                          out_accepted_reg;
    logic                          out_pfault_reg;
    logic                          out_efault_reg;
    logic                          out_jfault_reg;
    logic                          out_supd_reg;
    logic [TALLY_BITS-1:0]         out_ptally_reg;
    logic [TALLY_BITS-1:0]         out_etally_reg;
    logic [TALLY_BITS-1:0]         out_jtally_reg;

    // combinational
    logic                          parity_fault;
    logic                          error_bit;
    logic [ANGLE_BITS-1:0]         angle;
    logic signed [ANGLE_BITS:0]    angle_delta;
    logic signed [TURN_BITS-1:0]   turn_next;
    logic signed [POS_WIDE-1:0]    abs_wide;
    logic signed [POS_WIDE-1:0]    off_wide;
    logic signed [POS_WIDE-1:0]    pos_wide;
    logic signed [POS_BITS-1:0]    pos_next;
    logic [POS_BITS:0]             fwd_diff;
    logic [POS_BITS:0]             rev_diff;
    logic [POS_BITS:0]             abs_diff;
    logic                          jump_hit;
    logic [TIME_BITS-1:0]          dt;
    logic                          speed_due;
    logic signed [E_BITS-1:0]      e_next;
    logic [E_BITS-1:0]             e_mag;
    logic [INTEG_BITS-1:0]         omega_mag;
    logic                          clamp_neg;
    logic                          clamp_wide;
    logic                          clamp_over;
    logic [MUL_WIDTH-1:0]          clamp_q;
    logic                          clamp_round;
    logic [MUL_WIDTH:0]            clamp_qr;
    logic [RES_BITS-1:0]           clamp_cap;
    logic [RES_BITS-1:0]           clamp_mag;
    logic signed [RES_BITS-1:0]    res_next;
    logic signed [SUM_BITS-1:0]    integ_sum;
    logic signed [INTEG_BITS-1:0]  integ_sat;
    logic signed [SUM_BITS-1:0]    obs_sum;
    logic signed [OBS_BITS-1:0]    obs_next;
    logic [TALLY_BITS+TOTAL_BITS-1:0] ptally_ext;
    logic [TALLY_BITS+TOTAL_BITS-1:0] etally_ext;
    logic [TALLY_BITS+TOTAL_BITS-1:0] jtally_ext;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    eft_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // frame checks and turn unwrap
    always_comb
    begin
        parity_fault = ^raw_reg;
        error_bit    = raw_reg[ERR_BIT];
        angle        = raw_reg[ANGLE_BITS-1:0];
        angle_delta  = $signed({1'b0, angle}) - $signed({1'b0, last_angle_reg});
        turn_next    = turn_reg;
        if (angle_delta > HALF_TURN)
        begin
            if (turn_reg != TURN_LO)
                turn_next = turn_reg - TURN_BITS'(1);
        end
        else if (angle_delta < -HALF_TURN)
        begin
            if (turn_reg != TURN_HI)
                turn_next = turn_reg + TURN_BITS'(1);
        end
    end

    // position, jump and elapsed time
    always_comb
    begin
        abs_wide = POS_WIDE'($signed({turn_reg, last_angle_reg}));
        off_wide = POS_WIDE'(offset_reg);
        pos_wide = dir_ccw_reg ? (-abs_wide - off_wide) : (abs_wide - off_wide);
        if (pos_wide > POS_HI)
            pos_next = POS_HI[POS_BITS-1:0];
        else if (pos_wide < POS_LO)
            pos_next = POS_LO[POS_BITS-1:0];
        else
            pos_next = pos_wide[POS_BITS-1:0];

        fwd_diff  = {pos_reg[POS_BITS-1], pos_reg} - {last_pos_reg[POS_BITS-1], last_pos_reg};
        rev_diff  = {last_pos_reg[POS_BITS-1], last_pos_reg} - {pos_reg[POS_BITS-1], pos_reg};
        abs_diff  = fwd_diff[POS_BITS] ? rev_diff : fwd_diff;
        jump_hit  = abs_diff > (POS_BITS+1)'(jump_limit_reg);

        dt        = time_reg - last_time_reg;
        speed_due = dt > TIME_BITS'(MIN_DT_US);

        e_next    = E_BITS'($signed({pos_reg, 16'b0})) - E_BITS'(obs_reg);
        e_mag     = e_reg[E_BITS-1] ? E_BITS'(-e_reg) : E_BITS'(e_reg);
        omega_mag = omega_reg[INTEG_BITS-1] ? INTEG_BITS'(-omega_reg)
                                            : INTEG_BITS'(omega_reg);
    end

    // multiplier operands
    always_comb
    begin
        mul_req.start = (state_reg == S_GO);
        case (op_reg)
            OP_TS:
            begin
                mul_req.a = MUL_WIDTH'(dt_reg);
                mul_req.b = MUL_WIDTH'(TS_RECIP);
            end
            OP_GITS:
            begin
                mul_req.a = MUL_WIDTH'(ts_reg);
                mul_req.b = MUL_WIDTH'(gain_i_reg);
            end
            OP_INC:
            begin
                mul_req.a = MUL_WIDTH'(e_mag);
                mul_req.b = MUL_WIDTH'(gits_reg);
            end
            OP_P:
            begin
                mul_req.a = MUL_WIDTH'(e_mag);
                mul_req.b = MUL_WIDTH'(gain_p_reg);
            end
            OP_DTH:
            begin
                mul_req.a = MUL_WIDTH'(omega_mag);
                mul_req.b = MUL_WIDTH'(ts_reg);
            end
            default:
            begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    // floor(+-|a|*b / 2^s) from the magnitude product, clamped to the
    // signed 52-bit range (58-bit for the angle step)
    always_comb
    begin
        clamp_neg  = (op_reg == OP_DTH) ? omega_reg[INTEG_BITS-1] : e_reg[E_BITS-1];
        clamp_wide = (op_reg == OP_DTH);
        if (op_reg == OP_P)
        begin
            clamp_q     = mul_rsp.product[MUL_WIDTH-1:0];
            clamp_over  = |mul_rsp.product[PROD_WIDTH-1:MUL_WIDTH];
            clamp_round = 1'b0;
        end
        else
        begin
            clamp_q     = mul_rsp.product[MUL_WIDTH+MUL_LIMB-1:MUL_LIMB];
            clamp_over  = |mul_rsp.product[PROD_WIDTH-1:MUL_WIDTH+MUL_LIMB];
            clamp_round = clamp_neg && (|mul_rsp.product[MUL_LIMB-1:0]);
        end
        clamp_qr  = {1'b0, clamp_q} + (MUL_WIDTH+1)'(clamp_round);
        clamp_cap = clamp_wide ? (RES_BITS'(1) << 57) : (RES_BITS'(1) << 51);
        if (!clamp_neg)
            clamp_cap = clamp_cap - RES_BITS'(1);
        if (clamp_over || (clamp_qr > (MUL_WIDTH+1)'(clamp_cap)))
            clamp_mag = clamp_cap;
        else
            clamp_mag = clamp_qr[RES_BITS-1:0];
        res_next = clamp_neg ? -$signed(clamp_mag) : $signed(clamp_mag);
    end

    // integrator / omega share one adder; angle step has its own
    always_comb
    begin
        integ_sum = SUM_BITS'(res_reg) + SUM_BITS'(integ_reg);
        if (integ_sum > INTEG_HI)
            integ_sat = INTEG_HI[INTEG_BITS-1:0];
        else if (integ_sum < INTEG_LO)
            integ_sat = INTEG_LO[INTEG_BITS-1:0];
        else
            integ_sat = integ_sum[INTEG_BITS-1:0];

        obs_sum = SUM_BITS'(obs_reg) + SUM_BITS'(res_reg);
        if (obs_sum > OBS_HI)
            obs_next = OBS_HI[OBS_BITS-1:0];
        else if (obs_sum < OBS_LO)
            obs_next = OBS_LO[OBS_BITS-1:0];
        else
            obs_next = obs_sum[OBS_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_ccw_reg    <= 1'b0;
            offset_reg     <= '0;
            jump_limit_reg <= JUMP_LIMIT_RST;
            calibrated_reg <= 1'b0;
            gain_p_reg     <= GAIN_P_RST;
            gain_i_reg     <= GAIN_I_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_DIRECTION_CCW: dir_ccw_reg    <= cfg.data[0];
                CFG_OFFSET_COUNTS: offset_reg     <= OFFSET_BITS'(cfg.data);
                CFG_JUMP_LIMIT:    jump_limit_reg <= LIMIT_BITS'(cfg.data);
                CFG_CALIBRATED:    calibrated_reg <= cfg.data[0];
                CFG_GAIN_P:        gain_p_reg     <= cfg.data[GAIN_BITS-1:0];
                CFG_GAIN_I:        gain_i_reg     <= cfg.data[GAIN_BITS-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= OP_TS;
            raw_reg          <= '0;
            time_reg         <= '0;
            last_angle_reg   <= '0;
            turn_reg         <= '0;
            pos_reg          <= '0;
            last_pos_reg     <= '0;
            last_time_reg    <= '0;
            obs_reg          <= '0;
            integ_reg        <= '0;
            speed_reg        <= '0;
            ptally_reg       <= '0;
            etally_reg       <= '0;
            jtally_reg       <= '0;
            pfault_reg       <= 1'b0;
            efault_reg       <= 1'b0;
            jfault_reg       <= 1'b0;
            supd_reg         <= 1'b0;
            dt_reg           <= '0;
            e_reg            <= '0;
            ts_reg           <= '0;
            gits_reg         <= '0;
            res_reg          <= '0;
            omega_reg        <= '0;
            out_valid_reg    <= 1'b0;
            out_pos_reg      <= '0;
            out_speed_reg    <= '0;
            out_accepted_reg <= 1'b0;
            out_pfault_reg   <= 1'b0;
            out_efault_reg   <= 1'b0;
            out_jfault_reg   <= 1'b0;
            out_supd_reg     <= 1'b0;
            out_ptally_reg   <= '0;
            out_etally_reg   <= '0;
            out_jtally_reg   <= '0;
        end
        else
        begin
            if (result.valid && result.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (frame.valid)
                    begin
                        raw_reg   <= frame.raw_frame;
                        time_reg  <= frame.time_us;
                        state_reg <= S_CHECK;
                    end
                end

                S_CHECK:
                begin
                    pfault_reg <= parity_fault;
                    efault_reg <= error_bit;
                    jfault_reg <= 1'b0;
                    supd_reg   <= 1'b0;
                    if (parity_fault && (ptally_reg != TALLY_MAX))
                        ptally_reg <= ptally_reg + TALLY_BITS'(1);
                    if (error_bit && (etally_reg != TALLY_MAX))
                        etally_reg <= etally_reg + TALLY_BITS'(1);
                    if (!parity_fault && !error_bit)
                    begin
                        turn_reg       <= turn_next;
                        last_angle_reg <= angle;
                        state_reg      <= S_POS;
                    end
                    else
                        state_reg <= S_OUT;
                end

                S_POS:
                begin
                    pos_reg   <= pos_next;
                    state_reg <= S_JUMP;
                end

                S_JUMP:
                begin
                    jfault_reg   <= jump_hit;
                    if (jump_hit && (jtally_reg != TALLY_MAX))
                        jtally_reg <= jtally_reg + TALLY_BITS'(1);
                    last_pos_reg <= pos_reg;
                    dt_reg       <= dt;
                    e_reg        <= e_next;
                    if (speed_due)
                    begin
                        supd_reg      <= 1'b1;
                        last_time_reg <= time_reg;
                        if (calibrated_reg)
                        begin
                            op_reg    <= OP_TS;
                            state_reg <= S_GO;
                        end
                        else
                            state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_OUT;
                end

                S_GO:
                    state_reg <= S_WAIT;

                S_WAIT:
                begin
                    if (mul_rsp.done)
                        state_reg <= S_POST;
                end

                S_POST:
                begin
                    case (op_reg)
                        OP_TS:
                        begin
                            ts_reg    <= mul_rsp.product[TS_BITS-1:0];
                            op_reg    <= OP_GITS;
                            state_reg <= S_GO;
                        end
                        OP_GITS:
                        begin
                            gits_reg  <= mul_rsp.product[GITS_BITS-1:0];
                            op_reg    <= OP_INC;
                            state_reg <= S_GO;
                        end
                        OP_INC:
                        begin
                            res_reg   <= res_next;
                            state_reg <= S_INT;
                        end
                        OP_P:
                        begin
                            res_reg   <= res_next;
                            state_reg <= S_OMEGA;
                        end
                        OP_DTH:
                        begin
                            res_reg   <= res_next;
                            state_reg <= S_ANGLE;
                        end
                        default:
                            state_reg <= S_OUT;
                    endcase
                end

                S_INT:
                begin
                    integ_reg <= integ_sat;
                    op_reg    <= OP_P;
                    state_reg <= S_GO;
                end

                S_OMEGA:
                begin
                    // speed = floor(omega / 2^16)
                    omega_reg <= integ_sat;
                    speed_reg <= integ_sat[INTEG_BITS-1:INTEG_BITS-SPEED_BITS];
                    op_reg    <= OP_DTH;
                    state_reg <= S_GO;
                end

                S_ANGLE:
                begin
                    obs_reg   <= obs_next;
                    state_reg <= S_OUT;
                end

                S_OUT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_pos_reg      <= last_pos_reg;
                        out_speed_reg    <= speed_reg;
                        out_accepted_reg <= !pfault_reg && !efault_reg;
                        out_pfault_reg   <= pfault_reg;
                        out_efault_reg   <= efault_reg;
                        out_jfault_reg   <= jfault_reg;
                        out_supd_reg     <= supd_reg;
                        out_ptally_reg   <= ptally_reg;
                        out_etally_reg   <= etally_reg;
                        out_jtally_reg   <= jtally_reg;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign ptally_ext = {{TOTAL_BITS{1'b0}}, out_ptally_reg};
    assign etally_ext = {{TOTAL_BITS{1'b0}}, out_etally_reg};
    assign jtally_ext = {{TOTAL_BITS{1'b0}}, out_jtally_reg};

    assign cfg.ready                 = 1'b1;
    assign frame.ready               = (state_reg == S_IDLE);
    assign result.valid              = out_valid_reg;
    assign result.position           = out_pos_reg;
    assign result.speed              = out_speed_reg;
    assign result.sample_accepted    = out_accepted_reg;
    assign result.parity_fault       = out_pfault_reg;
    assign result.sensor_error_bit   = out_efault_reg;
    assign result.jump_fault         = out_jfault_reg;
    assign result.speed_updated      = out_supd_reg;
    assign result.parity_fault_total = ptally_ext[TOTAL_BITS-1:0];
    assign result.error_bit_total    = etally_ext[TOTAL_BITS-1:0];
    assign result.jump_fault_total   = jtally_ext[TOTAL_BITS-1:0];

    `EFT_ASSERT_IMP(a_done_in_wait, mul_rsp.done, state_reg == S_WAIT, "done outside wait")
    `EFT_ASSERT_IMP(a_turn_in_check, turn_reg != $past(turn_reg), $past(state_reg) == S_CHECK, "turn count moved outside frame check")
    `EFT_ASSERT_IMP(a_jump_tally, jtally_reg != $past(jtally_reg), jfault_reg, "jump tally moved without jump fault")

endmodule

// ===== design/eft_mul.sv =====
`include "encoder_frame_tracker_defines.svh"

// 64x64 unsigned multiply, one 32x32 limb product per cycle, registered
// product, accumulated in the cycle after. done pulses with the full product.
module eft_mul
    import eft_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [MUL_WIDTH-1:0]  a_reg;
    logic [MUL_WIDTH-1:0]  b_reg;
    logic [2:0]            cnt_reg;
    logic                  busy_reg;
    logic                  pvalid_reg;
    logic                  done_reg;
    logic [MUL_WIDTH-1:0]  prod_reg;
    logic [1:0]            pshift_reg;
    logic [PROD_WIDTH-1:0] acc_reg;

    logic [MUL_LIMB-1:0]   a_limb;
    logic [MUL_LIMB-1:0]   b_limb;
    logic [PROD_WIDTH-1:0] addend;

    always_comb
    begin
        a_limb = cnt_reg[1] ? a_reg[MUL_WIDTH-1:MUL_LIMB] : a_reg[MUL_LIMB-1:0];
        b_limb = cnt_reg[0] ? b_reg[MUL_WIDTH-1:MUL_LIMB] : b_reg[MUL_LIMB-1:0];
        case (pshift_reg)
            2'd0:    addend = {{MUL_WIDTH{1'b0}}, prod_reg};
            2'd1:    addend = {{MUL_LIMB{1'b0}}, prod_reg, {MUL_LIMB{1'b0}}};
            2'd2:    addend = {prod_reg, {MUL_WIDTH{1'b0}}};
            default: addend = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg      <= '0;
            b_reg      <= '0;
            cnt_reg    <= '0;
            busy_reg   <= 1'b0;
            pvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
            prod_reg   <= '0;
            pshift_reg <= '0;
            acc_reg    <= '0;
        end
        else if (req.start)
        begin
            a_reg      <= req.a;
            b_reg      <= req.b;
            cnt_reg    <= '0;
            busy_reg   <= 1'b1;
            pvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                if (cnt_reg != 3'(MUL_STEPS))
                begin
                    prod_reg   <= a_limb * b_limb;
                    pshift_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                    pvalid_reg <= 1'b1;
                    cnt_reg    <= cnt_reg + 3'd1;
                end
                else
                begin
                    // last product lands in the accumulator on this edge
                    pvalid_reg <= 1'b0;
                    busy_reg   <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
            if (pvalid_reg)
                acc_reg <= acc_reg + addend;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

    `EFT_ASSERT_IMP(a_start_idle, req.start, !busy_reg, "eft_mul: start while busy")
    `EFT_ASSERT_NXT(a_done_pulse, done_reg, !done_reg, "eft_mul: done held")
    `EFT_ASSERT_IMP(a_pvalid_busy, pvalid_reg, busy_reg, "eft_mul: product outside run")

endmodule

// ===== sim/testbench.sv =====
module testbench;
    import eft_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic signed [POS_BITS-1:0]   position;
        logic signed [SPEED_BITS-1:0] speed;
        logic                         sample_accepted;
        logic                         parity_fault;
        logic                         sensor_error_bit;
        logic                         jump_fault;
        logic                         speed_updated;
        logic [TOTAL_BITS-1:0]        parity_fault_total;
        logic [TOTAL_BITS-1:0]        error_bit_total;
        logic [TOTAL_BITS-1:0]        jump_fault_total;
    } tracker_report_t;

    localparam int COUNTS_PER_TURN = 1 << ANGLE_BITS;
    localparam int HALF_TURN       = COUNTS_PER_TURN / 2;
    localparam int FRAC_BITS       = 16;
    localparam int TS_SHIFT        = 32;
    localparam int TERM_BITS       = 52;   // integrator increment and P term clamp
    localparam int STEP_BITS       = 58;   // observer angle step clamp
    localparam int TALLY_MAX       = (1 << TALLY_BITS) - 1;
    localparam int IDLE_PERCENT    = 34;
    localparam int SETTLE_CYCLES   = 80;
    localparam int CYCLE_LIMIT     = 1000000;

    logic clk;
    logic rst_n;

    eft_cfg_if    cfg_bus();
    eft_frame_if  frame_bus();
    eft_result_if result_bus();

    encoder_frame_tracker dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .frame  (frame_bus),
        .result (result_bus)
    );

    // mirror of the register file
    logic  ccw_mode    = 1'b0;
    wide_t zero_offset = 0;
    wide_t jump_limit  = JUMP_LIMIT_RST;
    logic  obs_enabled = 1'b0;
    logic [GAIN_BITS-1:0] prop_gain  = GAIN_P_RST;
    logic [GAIN_BITS-1:0] integ_gain = GAIN_I_RST;

    // mirror of the tracking state
    logic [ANGLE_BITS-1:0] prev_angle     = '0;
    wide_t                 turns          = 0;
    wide_t                 held_position  = 0;
    logic [TIME_BITS-1:0]  prev_speed_us  = '0;
    wide_t                 obs_angle      = 0;
    wide_t                 obs_integral   = 0;
    wide_t                 held_speed     = 0;
    int                    parity_tally   = 0;
    int                    errbit_tally   = 0;
    int                    jump_tally     = 0;

    tracker_report_t awaited_reports[$];
    int              mismatch_count = 0;
    bit              no_stall = 1'b0;

    // stimulus-side sensor model
    int                   shaft_angle = 0;
    int                   shaft_drift = 0;
    logic [TIME_BITS-1:0] stamp_us    = '0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic wide_t clamp_signed(wide_t v, int bits);
        wide_t lim;
        lim = (wide_t'(1) <<< (bits - 1)) - 1;
        if (v > lim)
            return lim;
        if (v < -lim - 1)
            return -lim - 1;
        return v;
    endfunction

    function automatic tracker_report_t track_frame(logic [FRAME_BITS-1:0] raw,
                                                    logic [TIME_BITS-1:0] now);
        tracker_report_t rep;
        logic                 pfault;
        logic                 efault;
        logic [TIME_BITS-1:0] dt;
        wide_t ang, prev, step, pos, diff, ts, gain, err, inc, pterm, omega, dth;

        rep = '0;
        pfault = ^raw;
        efault = raw[ERR_BIT];
        if (pfault && parity_tally < TALLY_MAX)
            parity_tally++;
        if (efault && errbit_tally < TALLY_MAX)
            errbit_tally++;

        if (!pfault && !efault)
        begin
            ang  = raw[ANGLE_BITS-1:0];
            prev = prev_angle;
            step = ang - prev;
            // more than half a turn either way means the shaft wrapped
            if (step > HALF_TURN || step < -HALF_TURN)
                turns = clamp_signed(turns + (step > 0 ? -1 : 1), TURN_BITS);
            prev_angle = raw[ANGLE_BITS-1:0];

            pos = turns * COUNTS_PER_TURN + ang;
            pos = ccw_mode ? -pos - zero_offset : pos - zero_offset;
            pos = clamp_signed(pos, POS_BITS);
            diff = pos - held_position;
            if (diff < 0)
                diff = -diff;
            if (diff > jump_limit)
            begin
                rep.jump_fault = 1'b1;
                if (jump_tally < TALLY_MAX)
                    jump_tally++;
            end
            held_position = pos;

            dt = now - prev_speed_us;
            if (dt > MIN_DT_US)
            begin
                rep.speed_updated = 1'b1;
                if (obs_enabled)
                begin
                    ts = dt;
                    ts = ts * TS_RECIP;
                    err = held_position * (1 << FRAC_BITS) - obs_angle;
                    gain = integ_gain;
                    inc = clamp_signed((err * (gain * ts)) >>> TS_SHIFT, TERM_BITS);
                    obs_integral = clamp_signed(obs_integral + inc, INTEG_BITS);
                    gain = prop_gain;
                    pterm = clamp_signed(err * gain, TERM_BITS);
                    omega = clamp_signed(pterm + obs_integral, INTEG_BITS);
                    dth = clamp_signed((omega * ts) >>> TS_SHIFT, STEP_BITS);
                    obs_angle = clamp_signed(obs_angle + dth, OBS_BITS);
                    held_speed = omega >>> FRAC_BITS;
                end
                prev_speed_us = now;
            end
        end

        rep.position           = held_position[POS_BITS-1:0];
        rep.speed              = held_speed[SPEED_BITS-1:0];
        rep.sample_accepted    = !pfault && !efault;
        rep.parity_fault       = pfault;
        rep.sensor_error_bit   = efault;
        rep.parity_fault_total = parity_tally[TOTAL_BITS-1:0];
        rep.error_bit_total    = errbit_tally[TOTAL_BITS-1:0];
        rep.jump_fault_total   = jump_tally[TOTAL_BITS-1:0];
        return rep;
    endfunction

    function automatic logic [FRAME_BITS-1:0] make_frame(int angle, bit err_flag, bit bad_parity);
        logic [FRAME_BITS-1:0] f;
        f = '0;
        f[ANGLE_BITS-1:0] = angle[ANGLE_BITS-1:0];
        f[ERR_BIT] = err_flag;
        f[FRAME_BITS-1] = (^f[FRAME_BITS-2:0]) ^ bad_parity;
        return f;
    endfunction

    task automatic send_frame(logic [FRAME_BITS-1:0] raw, logic [TIME_BITS-1:0] stamp);
        @(negedge clk);
        while (!no_stall && $urandom_range(99) < IDLE_PERCENT)
        begin
            frame_bus.valid = 1'b0;
            @(negedge clk);
        end
        frame_bus.valid     = 1'b1;
        frame_bus.raw_frame = raw;
        frame_bus.time_us   = stamp;
        do
            @(posedge clk);
        while (!frame_bus.ready);
        awaited_reports.push_back(track_frame(raw, stamp));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        frame_bus.valid = 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            CFG_DIRECTION_CCW: ccw_mode    = value[0];
            CFG_OFFSET_COUNTS: zero_offset = signed'(value[OFFSET_BITS-1:0]);
            CFG_JUMP_LIMIT:    jump_limit  = value[LIMIT_BITS-1:0];
            CFG_CALIBRATED:    obs_enabled = value[0];
            CFG_GAIN_P:        prop_gain   = value[GAIN_BITS-1:0];
            CFG_GAIN_I:        integ_gain  = value[GAIN_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    // unused upper bits of the narrow registers carry junk to check masking
    task automatic load_settings(bit ccw, logic [OFFSET_BITS-1:0] offset,
                                 logic [LIMIT_BITS-1:0] limit, bit cal,
                                 logic [GAIN_BITS-1:0] gp, logic [GAIN_BITS-1:0] gi);
        logic [CFG_DATA_BITS-1:0] junk;
        junk = $urandom;
        cfg_write(CFG_DIRECTION_CCW, {junk[CFG_DATA_BITS-1:1], ccw});
        cfg_write(CFG_OFFSET_COUNTS, offset);
        cfg_write(CFG_JUMP_LIMIT, limit);
        cfg_write(CFG_CALIBRATED, {junk[CFG_DATA_BITS-2:0], cal});
        cfg_write(CFG_GAIN_P, {junk[CFG_DATA_BITS-1:GAIN_BITS], gp});
        cfg_write(CFG_GAIN_I, {junk[GAIN_BITS+7:GAIN_BITS], gi});
    endtask

    task automatic send_random_frames(int count);
        int                    roll;
        logic [FRAME_BITS-1:0] raw;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 70)
            begin
                shaft_angle = (shaft_angle + shaft_drift + $urandom_range(40) - 20)
                              & (COUNTS_PER_TURN - 1);
                stamp_us += $urandom_range(400);
                raw = make_frame(shaft_angle, 1'b0, 1'b0);
            end
            else if (roll < 80)
            begin
                shaft_angle = $urandom_range(COUNTS_PER_TURN - 1);
                stamp_us += $urandom_range(3000);
                raw = make_frame(shaft_angle, 1'b0, 1'b0);
            end
            else if (roll < 87)
            begin
                stamp_us += $urandom_range(400);
                raw = make_frame($urandom, 1'b0, 1'b1);
            end
            else if (roll < 93)
            begin
                stamp_us += $urandom_range(400);
                raw = make_frame($urandom, 1'b1, $urandom_range(1));
            end
            else if (roll < 97)
            begin
                // long gap in the timestamp, possibly past the wrap
                shaft_angle = (shaft_angle + shaft_drift) & (COUNTS_PER_TURN - 1);
                stamp_us += $urandom;
                raw = make_frame(shaft_angle, 1'b0, 1'b0);
            end
            else
            begin
                stamp_us = $urandom;
                raw = $urandom;
            end
            send_frame(raw, stamp_us);
            if ($urandom_range(199) == 0)
                wait_drained();
        end
    endtask

    task automatic run_phase(bit ccw, logic [OFFSET_BITS-1:0] offset,
                             logic [LIMIT_BITS-1:0] limit, bit cal,
                             logic [GAIN_BITS-1:0] gp, logic [GAIN_BITS-1:0] gi, int count);
        wait_drained();
        load_settings(ccw, offset, limit, cal, gp, gi);
        shaft_drift = $urandom_range(600) - 300;
        send_random_frames(count);
    endtask

    // parity, error bit, unwrap boundaries, jump threshold and timing edges
    task automatic test_frame_cases();
        send_frame(make_frame(0, 1'b0, 1'b0), 32'd40);
        send_frame(make_frame(100, 1'b0, 1'b0), 32'd100);     // exactly 100 us: no update
        send_frame(make_frame(200, 1'b0, 1'b0), 32'd101);     // update while uncalibrated
        send_frame(make_frame(5000, 1'b0, 1'b1), 32'd500);    // parity fault, held outputs
        send_frame(make_frame(5000, 1'b1, 1'b0), 32'd600);    // error bit only
        send_frame(make_frame(5000, 1'b1, 1'b1), 32'd700);    // both faults
        send_frame(16'hFFFF, 32'd800);
        send_frame(make_frame(16383, 1'b0, 1'b0), 32'd900);   // wraps back a turn
        send_frame(make_frame(0, 1'b0, 1'b0), 32'd1000);      // and forward again
        send_frame(make_frame(8192, 1'b0, 1'b0), 32'd1100);   // exactly half a turn
        send_frame(make_frame(0, 1'b0, 1'b0), 32'd1150);
        send_frame(make_frame(8193, 1'b0, 1'b0), 32'd1300);
        send_frame(make_frame(0, 1'b0, 1'b0), 32'd1400);
        send_frame(make_frame(2048, 1'b0, 1'b0), 32'd1500);   // on the jump limit
        send_frame(make_frame(4097, 1'b0, 1'b0), 32'd1600);   // just over it
        send_frame(make_frame(4097, 1'b0, 1'b0), 32'hFFFF_FF00);
        send_frame(make_frame(4100, 1'b0, 1'b0), 32'h0000_0010);
        send_frame(make_frame(16383, 1'b1, 1'b1), 32'hFFFF_FFFF);
        send_frame(make_frame(14'h2AAA, 1'b0, 1'b0), 32'h8000_0000);
        send_frame(make_frame(14'h1555, 1'b0, 1'b0), 32'h5555_5555);
        send_frame(16'h0000, 32'hAAAA_AAAA);
        shaft_angle = 14'h1555;
        stamp_us    = 32'hAAAA_AAAA;
    endtask

    task automatic test_register_extremes();
        wait_drained();
        // writes to unmapped indexes must leave every register alone
        for (int idx = CFG_GAIN_I + 1; idx < (1 << CFG_INDEX_BITS); idx++)
            cfg_write(idx, $urandom);
        send_random_frames(10);
        run_phase(1'b1, 24'h800000, 24'd0, 1'b1, 16'hFFFF, 16'hFFFF, 240);
        run_phase(1'b0, 24'h7FFFFF, 24'hFFFFFF, 1'b1, 16'd0, 16'd0, 250);
    endtask

    task automatic test_tracking_defaults();
        run_phase(1'b0, 24'd0, JUMP_LIMIT_RST, 1'b1, GAIN_P_RST, GAIN_I_RST, 250);
    endtask

    task automatic test_uncalibrated();
        run_phase($urandom_range(1), $urandom, $urandom_range(4096), 1'b0,
                  $urandom, $urandom, 200);
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 3; p++)
            run_phase($urandom_range(1), $urandom, $urandom_range(8191),
                      $urandom_range(9) != 0, $urandom_range(2000), $urandom_range(5000), 250);
    endtask

    task automatic test_steady_stream();
        run_phase($urandom_range(1), $urandom, $urandom, 1'b1, $urandom, $urandom, 10);
        no_stall = 1'b1;
        send_random_frames(150);
        no_stall = 1'b0;
    endtask

    task automatic compare_field(string name, logic signed [63:0] want,
                                 logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_report();
        tracker_report_t want;
        if (awaited_reports.size() == 0)
        begin
            $error("result transaction with no frame outstanding");
            mismatch_count++;
        end
        else
        begin
            want = awaited_reports.pop_front();
            compare_field("position", want.position, result_bus.position);
            compare_field("speed", want.speed, result_bus.speed);
            compare_field("sample_accepted", want.sample_accepted, result_bus.sample_accepted);
            compare_field("parity_fault", want.parity_fault, result_bus.parity_fault);
            compare_field("sensor_error_bit", want.sensor_error_bit,
                          result_bus.sensor_error_bit);
            compare_field("jump_fault", want.jump_fault, result_bus.jump_fault);
            compare_field("speed_updated", want.speed_updated, result_bus.speed_updated);
            compare_field("parity_fault_total", want.parity_fault_total,
                          result_bus.parity_fault_total);
            compare_field("error_bit_total", want.error_bit_total, result_bus.error_bit_total);
            compare_field("jump_fault_total", want.jump_fault_total,
                          result_bus.jump_fault_total);
        end
    endtask

    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready)
                check_report();
            @(negedge clk);
            result_bus.ready = no_stall || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        frame_bus.valid     = 1'b0;
        frame_bus.raw_frame = '0;
        frame_bus.time_us   = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = '0;
        cfg_bus.data        = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_frame_cases();
        test_register_extremes();
        test_tracking_defaults();
        test_uncalibrated();
        test_random_settings();
        test_steady_stream();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/eft_pkg.sv
design/eft_if.sv
design/eft_mul.sv
design/encoder_frame_tracker.sv
sim/testbench.sv
